// ===== src/fwrl_pkg.sv =====
// ----------------------------------------------------------------------------
// fwrl_pkg
// Shared types and constants of the per-client fixed-window rate limiter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fwrl_pkg;

    localparam int TABLE_DEPTH_DEFAULT = 64;

    localparam int ADDR_W   = 64;
    localparam int TIME_W   = 32;
    localparam int COUNT_W  = 16;
    localparam int CFG_W    = 16;

    // APB register file
    localparam int APB_DW      = 32;
    localparam int APB_AW      = 3;
    localparam int REG_SEL_BIT = 2;

    localparam logic REG_WINDOW_SECONDS = 1'b0;
    localparam logic REG_REQ_LIMIT      = 1'b1;

    localparam logic [CFG_W-1:0] WINDOW_SECONDS_RESET = 16'd60;
    localparam logic [CFG_W-1:0] REQ_LIMIT_RESET      = 16'd100;

    typedef enum logic [1:0] {
        VERDICT_NEW     = 2'd0,
        VERDICT_COUNTED = 2'd1,
        VERDICT_FULL    = 2'd2,
        VERDICT_OVER    = 2'd3
    } t_verdict;

    typedef struct packed {
        logic [CFG_W-1:0] window_seconds;
        logic [CFG_W-1:0] req_limit;
    } t_cfg;

    typedef struct packed {
        logic               valid;
        logic [ADDR_W-1:0]  addr_high;
        logic [ADDR_W-1:0]  addr_low;
        logic [TIME_W-1:0]  win_open;
        logic [COUNT_W-1:0] count;
    } t_entry;

endpackage

// ===== src/fwrl_req_if.sv =====
// ----------------------------------------------------------------------------
// fwrl_req_if
// Request channel: client address halves and timestamp.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface fwrl_req_if
    import fwrl_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] client_addr_high;
    logic [ADDR_W-1:0] client_addr_low;
    logic [TIME_W-1:0] now_seconds;

    modport source (
        output valid, client_addr_high, client_addr_low, now_seconds,
        input  ready
    );

    modport sink (
        input  valid, client_addr_high, client_addr_low, now_seconds,
        output ready
    );
endinterface

// ===== src/fwrl_rsp_if.sv =====
// ----------------------------------------------------------------------------
// fwrl_rsp_if
// Result channel: allow flag and verdict code for one request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface fwrl_rsp_if
    import fwrl_pkg::*;
();
    logic     valid;
    logic     ready;
    logic     allowed;
    t_verdict verdict;

    modport source (
        output valid, allowed, verdict,
        input  ready
    );

    modport sink (
        input  valid, allowed, verdict,
        output ready
    );
endinterface

// ===== src/fwrl_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// fwrl_cfg_regs
// APB register file holding the window length and the request limit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fwrl_cfg_regs
    import fwrl_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;
    logic wr_fire;

    assign pready  = 1'b1;
    assign wr_fire = psel && penable && pwrite;
    assign o_cfg   = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_fire) begin
            case (paddr[REG_SEL_BIT])
                REG_WINDOW_SECONDS: n_cfg.window_seconds = pwdata[CFG_W-1:0];
                REG_REQ_LIMIT:      n_cfg.req_limit      = pwdata[CFG_W-1:0];
                default:            n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        case (paddr[REG_SEL_BIT])
            REG_WINDOW_SECONDS: prdata = {{(APB_DW-CFG_W){1'b0}}, r_cfg.window_seconds};
            REG_REQ_LIMIT:      prdata = {{(APB_DW-CFG_W){1'b0}}, r_cfg.req_limit};
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window_seconds <= WINDOW_SECONDS_RESET;
            r_cfg.req_limit      <= REQ_LIMIT_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ===== src/fwrl_table.sv =====
// ----------------------------------------------------------------------------
// fwrl_table
// Client table memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fwrl_table
    import fwrl_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT,
    localparam int IW = $clog2(TABLE_DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_rd_en,
    input  logic [IW-1:0] i_rd_addr,
    output t_entry        o_rd_data,
    input  logic          i_wr_en,
    input  logic [IW-1:0] i_wr_addr,
    input  t_entry        i_wr_data
);

    t_entry r_mem [TABLE_DEPTH];
    t_entry r_rd_data;

    assign o_rd_data = r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

// ===== src/fwrl_engine.sv =====
// ----------------------------------------------------------------------------
// fwrl_engine
// Sweeps the table per request: purges expired entries, finds the client
// and the lowest free slot, then writes back the update and the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fwrl_engine
    import fwrl_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT,
    localparam int IW = $clog2(TABLE_DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    fwrl_req_if.sink          i_req,
    fwrl_rsp_if.source        o_rsp,
    output logic              o_rd_en,
    output logic [IW-1:0]     o_rd_addr,
    input  t_entry            i_rd_data,
    output logic              o_wr_en,
    output logic [IW-1:0]     o_wr_addr,
    output t_entry            o_wr_data
);

    localparam logic [IW-1:0] LAST = IW'(TABLE_DEPTH - 1);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_UPDATE
    } t_state;

    t_state             r_state,      n_state;
    logic [IW-1:0]      r_didx,       n_didx;
    logic [ADDR_W-1:0]  r_hi,         n_hi;
    logic [ADDR_W-1:0]  r_lo,         n_lo;
    logic [TIME_W-1:0]  r_now,        n_now;
    logic               r_hit,        n_hit;
    logic [IW-1:0]      r_hit_idx,    n_hit_idx;
    logic [COUNT_W-1:0] r_hit_count,  n_hit_count;
    logic [TIME_W-1:0]  r_hit_start,  n_hit_start;
    logic               r_free,       n_free;
    logic [IW-1:0]      r_free_idx,   n_free_idx;
    logic               r_out_valid,  n_out_valid;
    logic               r_allowed,    n_allowed;
    t_verdict           r_verdict,    n_verdict;

    logic [TIME_W-1:0]  age;
    logic               expired;
    logic               live;
    logic               match;
    logic               out_free;
    logic               req_fire;

    assign i_req.ready   = (r_state == S_IDLE);
    assign req_fire      = i_req.valid && i_req.ready;
    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.allowed = r_allowed;
    assign o_rsp.verdict = r_verdict;
    assign out_free      = !r_out_valid || o_rsp.ready;

    assign age     = r_now - i_rd_data.win_open;
    assign expired = i_rd_data.valid && (age >= {{(TIME_W-CFG_W){1'b0}}, i_cfg.window_seconds});
    assign live    = i_rd_data.valid && !expired;
    assign match   = (i_rd_data.addr_high == r_hi) && (i_rd_data.addr_low == r_lo);

    always_comb begin
        n_state     = r_state;
        n_didx      = r_didx;
        n_hi        = r_hi;
        n_lo        = r_lo;
        n_now       = r_now;
        n_hit       = r_hit;
        n_hit_idx   = r_hit_idx;
        n_hit_count = r_hit_count;
        n_hit_start = r_hit_start;
        n_free      = r_free;
        n_free_idx  = r_free_idx;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_allowed   = r_allowed;
        n_verdict   = r_verdict;

        o_rd_en   = 1'b0;
        o_rd_addr = r_didx + IW'(1);
        o_wr_en   = 1'b0;
        o_wr_addr = r_didx;
        o_wr_data = i_rd_data;
        o_wr_data.valid = 1'b0;

        case (r_state)
            S_CLEAR: begin
                o_wr_en   = 1'b1;
                o_wr_data = '0;
                if (r_didx == LAST) begin
                    n_didx  = '0;
                    n_state = S_IDLE;
                end else begin
                    n_didx = r_didx + IW'(1);
                end
            end
            S_IDLE: begin
                if (req_fire) begin
                    n_hi      = i_req.client_addr_high;
                    n_lo      = i_req.client_addr_low;
                    n_now     = i_req.now_seconds;
                    n_hit     = 1'b0;
                    n_free    = 1'b0;
                    n_didx    = '0;
                    o_rd_en   = 1'b1;
                    o_rd_addr = '0;
                    n_state   = S_SCAN;
                end
            end
            S_SCAN: begin
                // drop the expired entry in place; read of the next one is a different slot
                o_wr_en = expired;
                if (live && match && !r_hit) begin
                    n_hit       = 1'b1;
                    n_hit_idx   = r_didx;
                    n_hit_count = i_rd_data.count;
                    n_hit_start = i_rd_data.win_open;
                end
                if (!live && !r_free) begin
                    n_free     = 1'b1;
                    n_free_idx = r_didx;
                end
                if (r_didx == LAST) begin
                    n_state = S_UPDATE;
                end else begin
                    o_rd_en = 1'b1;
                    n_didx  = r_didx + IW'(1);
                end
            end
            S_UPDATE: begin
                // hold until the result register can take the verdict
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                    if (r_hit) begin
                        if (r_hit_count >= i_cfg.req_limit) begin
                            n_verdict = VERDICT_OVER;
                            n_allowed = 1'b0;
                        end else begin
                            n_verdict = VERDICT_COUNTED;
                            n_allowed = 1'b1;
                            o_wr_en   = 1'b1;
                            o_wr_addr = r_hit_idx;
                            o_wr_data = '{valid: 1'b1, addr_high: r_hi, addr_low: r_lo,
                                          win_open: r_hit_start,
                                          count: r_hit_count + COUNT_W'(1)};
                        end
                    end else if (r_free) begin
                        n_verdict = VERDICT_NEW;
                        n_allowed = 1'b1;
                        o_wr_en   = 1'b1;
                        o_wr_addr = r_free_idx;
                        o_wr_data = '{valid: 1'b1, addr_high: r_hi, addr_low: r_lo,
                                      win_open: r_now, count: COUNT_W'(1)};
                    end else begin
                        n_verdict = VERDICT_FULL;
                        n_allowed = 1'b0;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_didx      <= '0;
            r_hit       <= 1'b0;
            r_free      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_didx      <= n_didx;
            r_hit       <= n_hit;
            r_free      <= n_free;
            r_out_valid <= n_out_valid;
        end
        r_hi        <= n_hi;
        r_lo        <= n_lo;
        r_now       <= n_now;
        r_hit_idx   <= n_hit_idx;
        r_hit_count <= n_hit_count;
        r_hit_start <= n_hit_start;
        r_free_idx  <= n_free_idx;
        r_allowed   <= n_allowed;
        r_verdict   <= n_verdict;
    end

    a_no_rw_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_wr_en && o_rd_en) |-> (o_wr_addr != o_rd_addr))
        else $error("table read and write hit the same entry");

    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !o_wr_en)
        else $error("table written while idle");

    a_hit_behind_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && r_hit) |-> (r_hit_idx < r_didx))
        else $error("hit index ahead of sweep");

    a_free_behind_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && r_free) |-> (r_free_idx < r_didx))
        else $error("free slot index ahead of sweep");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_rsp.ready) |=> (r_out_valid && $stable(r_verdict)))
        else $error("pending result overwritten");

endmodule

// ===== src/per_client_fixed_window_rate_limiter.sv =====
// ----------------------------------------------------------------------------
// per_client_fixed_window_rate_limiter
// Per-client fixed-window request limiter over a table of client entries.
// A request is taken only while idle, so the next one waits for the previous
// result: the single read port sweeps every table entry once per request, an
// update state then writes the entry and registers the verdict, and the engine
// returns to idle to take the next request; a stalled result holds the update.
// Reset: a clearing pass over every entry invalidates the table; requests are
// held off until it ends, configuration writes are taken throughout.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module per_client_fixed_window_rate_limiter
    import fwrl_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    fwrl_req_if.sink          i_req,
    fwrl_rsp_if.source        o_rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int IW = $clog2(TABLE_DEPTH);

    t_cfg          cfg;
    logic          rd_en;
    logic [IW-1:0] rd_addr;
    t_entry        rd_data;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    t_entry        wr_data;

    fwrl_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    fwrl_table #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    fwrl_engine #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_req     (i_req),
        .o_rsp     (o_rsp),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data)
    );

endmodule
